@@ rtl/swo_pkg.sv @@
// Package for the sine oscillator: payload types, fixed widths and the sine ROM contents.
package swo_pkg;

	localparam int TABLE_SIZE   = 1024;
	localparam int SAMPLE_WIDTH = 16;
	localparam int PHASE_WIDTH  = 32;
	localparam int IDX_WIDTH    = $clog2(TABLE_SIZE);
	localparam int WEIGHT_WIDTH = 16;
	localparam int CFG_IDX_WIDTH = 2;

	// register indexes on the config port
	localparam logic [CFG_IDX_WIDTH-1:0] REG_PHASE_STEP   = 2'd0;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_PHASE_OFFSET = 2'd1;

	localparam logic [PHASE_WIDTH-1:0] PHASE_STEP_RESET   = 32'd89478485;
	localparam logic [PHASE_WIDTH-1:0] PHASE_OFFSET_RESET = 32'd0;

	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
	localparam logic [63:0] AMPLITUDE   = (64'd1 << (SAMPLE_WIDTH - 1)) - 64'd1;

	typedef struct packed {
		logic restart;
		logic end_of_block;
	} tick_t;

	typedef struct packed {
		logic signed [SAMPLE_WIDTH-1:0] sample;
		logic                           block_last;
	} smp_t;

	// work handed from front to back: table index, interpolation weight, block mark
	typedef struct packed {
		logic [IDX_WIDTH-1:0]    idx;
		logic [WEIGHT_WIDTH-1:0] weight;
		logic                    eob;
	} job_t;

	typedef logic signed [SAMPLE_WIDTH-1:0] sine_rom_t [TABLE_SIZE];

	function automatic logic [63:0] q30_one_minus(input logic [63:0] term);
		return (term >= Q30_ONE) ? 64'd0 : (Q30_ONE - term);
	endfunction

	// One sine period, Q30 Taylor series folded into the first quadrant.
	// Evaluated at elaboration only.
	function automatic sine_rom_t build_sine_rom();
		sine_rom_t   rom;
		logic [63:0] four_i;
		logic [63:0] quad;
		logic [63:0] rem;
		logic [63:0] num;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] s;
		logic [63:0] v;
		for (int i = 0; i < TABLE_SIZE; i++) begin
			four_i = 64'(4 * i);
			quad   = four_i / TABLE_SIZE;
			rem    = four_i % TABLE_SIZE;
			num    = quad[0] ? (64'(TABLE_SIZE) - rem) : rem;
			x      = (num * HALF_PI_Q30) / TABLE_SIZE;
			x2     = (x * x) >> 30;
			t      = Q30_ONE;
			t      = q30_one_minus(((x2 * t) >> 30) / 210);
			t      = q30_one_minus(((x2 * t) >> 30) / 156);
			t      = q30_one_minus(((x2 * t) >> 30) / 110);
			t      = q30_one_minus(((x2 * t) >> 30) / 72);
			t      = q30_one_minus(((x2 * t) >> 30) / 42);
			t      = q30_one_minus(((x2 * t) >> 30) / 20);
			t      = q30_one_minus(((x2 * t) >> 30) / 6);
			s      = (x * t) >> 30;
			v      = (s * AMPLITUDE + (64'd1 << 29)) >> 30;
			if (v > AMPLITUDE) begin
				v = AMPLITUDE;
			end
			rom[i] = (quad >= 64'd2) ? SAMPLE_WIDTH'(64'd0 - v) : SAMPLE_WIDTH'(v);
		end
		return rom;
	endfunction

endpackage

@@ rtl/sine_wavetable_oscillator_unit.sv @@
// Top level of the DDS sine oscillator with linear interpolation between ROM entries.
//
//  channel | handshake               | payload
//  --------+-------------------------+------------------------------------------
//  tick    | tick_valid / tick_stall | tick_data  : restart, end_of_block
//  smp     | smp_valid / smp_stall   | smp_data   : sample (Q1.15), block_last
//  cfg     | cfg_valid / cfg_ready   | cfg_index, cfg_data (0 step, 1 offset)
//
// One beat per clock sustained while smp_stall is low; a tick is written to the queue when
// accepted, then passes the ROM read, multiply and output register stages to smp_valid. The
// two-port sine ROM read and the single 17x17 multiply each take one stage of the back end.
// Reset clears the accumulator, queue and stage valids; the ROM is constant, no fill pass.
// smp_stall only freezes the back end; ticks keep landing in the queue until it is full,
// and tick_stall is the queue-full flag decoded from the registered queue count.
module sine_wavetable_oscillator_unit #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              tick_valid,
	output logic                              tick_stall,
	input  swo_pkg::tick_t                    tick_data,
	output logic                              smp_valid,
	input  logic                              smp_stall,
	output swo_pkg::smp_t                     smp_data,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [swo_pkg::CFG_IDX_WIDTH-1:0] cfg_index,
	input  logic [swo_pkg::PHASE_WIDTH-1:0]   cfg_data
);
	import swo_pkg::*;

	logic push;
	job_t push_job;
	logic q_full;
	logic q_not_empty;
	job_t q_head;
	logic pop;

	// registers are plain flops, always writable
	assign cfg_ready  = 1'b1;
	assign tick_stall = q_full;

	// front: phase accumulator and phase-to-index split, one tick per cycle while the queue is not full
	swo_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.tick_valid (tick_valid),
		.tick_data  (tick_data),
		.q_full     (q_full),
		.push       (push),
		.push_job   (push_job)
	);

	// decoupling queue; absorbs output backpressure
	swo_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_job  (push_job),
		.pop       (pop),
		.full      (q_full),
		.not_empty (q_not_empty),
		.head      (q_head)
	);

	// back: ROM lookup, interpolation, output register
	swo_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_avail (q_not_empty),
		.job       (q_head),
		.pop       (pop),
		.smp_valid (smp_valid),
		.smp_stall (smp_stall),
		.smp_data  (smp_data)
	);

endmodule

@@ rtl/swo_front.sv @@
// Front end: config registers, phase accumulator, phase split into table index and weight.
module swo_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	input  logic [swo_pkg::CFG_IDX_WIDTH-1:0]   cfg_index,
	input  logic [swo_pkg::PHASE_WIDTH-1:0]     cfg_data,
	input  logic                                tick_valid,
	input  swo_pkg::tick_t                      tick_data,
	input  logic                                q_full,
	output logic                                push,
	output swo_pkg::job_t                       push_job
);
	import swo_pkg::*;

	logic [PHASE_WIDTH-1:0] step_q;
	logic [PHASE_WIDTH-1:0] offset_q;
	logic [PHASE_WIDTH-1:0] acc_q;
	logic [PHASE_WIDTH-1:0] base;
	logic [PHASE_WIDTH-1:0] phase;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q   <= PHASE_STEP_RESET;
			offset_q <= PHASE_OFFSET_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_PHASE_STEP:   step_q   <= cfg_data;
				REG_PHASE_OFFSET: offset_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign push = tick_valid && !q_full;

	// restart zeroes the accumulator ahead of this beat
	assign base  = tick_data.restart ? '0 : acc_q;
	assign phase = base + offset_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (push) begin
			acc_q <= base + step_q;
		end
	end

	assign push_job.idx    = phase[PHASE_WIDTH-1 -: IDX_WIDTH];
	assign push_job.weight = phase[PHASE_WIDTH-IDX_WIDTH-1 -: WEIGHT_WIDTH];
	assign push_job.eob    = tick_data.end_of_block;

endmodule

@@ rtl/swo_fifo.sv @@
// Short job queue between the phase front end and the interpolation back end.
module swo_fifo #(
	parameter int DEPTH = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  swo_pkg::job_t  push_job,
	input  logic           pop,
	output logic           full,
	output logic           not_empty,
	output swo_pkg::job_t  head
);
	import swo_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	job_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = (count_q == FULL_CNT);
	assign not_empty = (count_q != '0);
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ rtl/swo_back.sv @@
// Back end: two-port sine ROM read, interpolation multiply, rounding add, output register.
module swo_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           job_avail,
	input  swo_pkg::job_t  job,
	output logic           pop,
	output logic           smp_valid,
	input  logic           smp_stall,
	output swo_pkg::smp_t  smp_data
);
	import swo_pkg::*;

	localparam sine_rom_t SINE_ROM = build_sine_rom();
	localparam int PROD_W = 2 * (SAMPLE_WIDTH + 1);

	logic                           v_s1, v_s2, v_s3;
	logic                           rdy1, rdy2, rdy3;
	logic signed [SAMPLE_WIDTH-1:0] a_s1, b_s1, a_s2;
	logic [WEIGHT_WIDTH-1:0]        w_s1;
	logic                           eob_s1, eob_s2;
	logic signed [PROD_W-1:0]       prod_s2;
	logic signed [SAMPLE_WIDTH:0]   diff;
	logic signed [PROD_W-1:0]       rounded;
	logic signed [SAMPLE_WIDTH+1:0] corr;
	logic signed [SAMPLE_WIDTH+1:0] sum;
	logic [IDX_WIDTH-1:0]           next_idx;
	smp_t                           out_s3;

	assign rdy3 = !v_s3 || !smp_stall;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign pop  = job_avail && rdy1;

	// entry after the last wraps to entry zero
	assign next_idx = job.idx + 1'b1;

	always_ff @(posedge clk) begin
		if (rdy1) begin
			a_s1   <= SINE_ROM[job.idx];
			b_s1   <= SINE_ROM[next_idx];
			w_s1   <= job.weight;
			eob_s1 <= job.eob;
		end
	end

	assign diff = (SAMPLE_WIDTH + 1)'(b_s1) - (SAMPLE_WIDTH + 1)'(a_s1);

	always_ff @(posedge clk) begin
		if (rdy2) begin
			prod_s2 <= PROD_W'(diff) * PROD_W'($signed({1'b0, w_s1}));
			a_s2    <= a_s1;
			eob_s2  <= eob_s1;
		end
	end

	// a + floor(((b - a) * w + 2^15) / 2^16)
	assign rounded = prod_s2 + PROD_W'(32768);
	assign corr    = rounded[PROD_W-1 -: SAMPLE_WIDTH + 2];
	assign sum     = (SAMPLE_WIDTH + 2)'(a_s2) + corr;

	always_ff @(posedge clk) begin
		if (rdy3) begin
			out_s3.sample     <= sum[SAMPLE_WIDTH-1:0];
			out_s3.block_last <= eob_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= pop;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
		end
	end

	assign smp_valid = v_s3;
	assign smp_data  = out_s3;

endmodule
